### rtl/core/ryc_pkg.sv
// ----------------------------------------------------------------------------
// ryc_pkg
// Shared types, register codes and constants of the RGB to YUV 4:2:0
// column converter.
// ----------------------------------------------------------------------------
package ryc_pkg;

  // geometry defaults
  localparam int DEF_MAX_HEIGHT  = 256;
  localparam int DEF_MAX_COLUMNS = 512;

  // register file
  localparam int CFG_INDEX_W  = 2;
  localparam int CFG_DATA_W   = 10;
  localparam int FORMAT_W     = 4;
  localparam int COLUMNS_W    = 10;
  localparam int HEIGHT_W     = 9;

  localparam logic [CFG_INDEX_W-1:0] REG_PIXEL_FORMAT  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_COLUMNS = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_COLUMN_HEIGHT = 2'd2;

  localparam logic [FORMAT_W-1:0]  FMT_BGR24  = 4'd1;
  localparam logic [FORMAT_W-1:0]  FMT_RGB565 = 4'd2;

  localparam logic [FORMAT_W-1:0]  RST_PIXEL_FORMAT  = FMT_BGR24;
  localparam logic [COLUMNS_W-1:0] RST_FRAME_COLUMNS = 10'd400;
  localparam logic [HEIGHT_W-1:0]  RST_COLUMN_HEIGHT = 9'd240;

  // stream widths
  localparam int PIXEL_W  = 24;
  localparam int OUT_W    = 40;
  localparam int OUT_USER_W = 2;

  // conversion weights
  localparam logic [16:0] WY_R = 17'd77;
  localparam logic [16:0] WY_G = 17'd150;
  localparam logic [16:0] WY_B = 17'd29;
  localparam logic signed [17:0] WU_R = -18'sd43;
  localparam logic signed [17:0] WU_G = -18'sd84;
  localparam logic signed [17:0] WU_B = 18'sd127;
  localparam logic signed [17:0] WV_R = 18'sd127;
  localparam logic signed [17:0] WV_G = -18'sd106;
  localparam logic signed [17:0] WV_B = -18'sd21;
  localparam logic [16:0] Y_ROUND = 17'd128;
  localparam logic signed [17:0] C_ROUND = 18'sd128;
  localparam logic [7:0] C_OFFSET = 8'd128;

  localparam int PAIR_W = 9;

  typedef struct packed {
    logic       format_error;
    logic [7:0] luma;
    logic [7:0] chroma_blue;
    logic [7:0] chroma_red;
  } pixel_t;

  typedef struct packed {
    logic [PAIR_W-1:0] blue;
    logic [PAIR_W-1:0] red;
  } pair_t;

endpackage

### rtl/core/rgb_to_yuv420_column_converter.sv
// ----------------------------------------------------------------------------
// rgb_to_yuv420_column_converter
// Column-major framebuffer pixels to Y/U/V per pixel plus 2x2-averaged chroma.
// ----------------------------------------------------------------------------
// One pixel beat in, one result beat out. Pixels are taken one per clock
// while the result side accepts; each passes an input register and then a
// result register, and the sustained rate is one pixel per cycle while
// m_tready holds, set by the single conversion stage. The pair-sum store is
// read one pixel ahead (on the even row) so its registered read lands in time
// for the odd row. No clearing pass after reset. Result tdata: luma,
// chroma_blue, chroma_red, sub_blue, sub_red; tuser: sub_valid, format_error;
// tlast marks the last pixel of a frame.
module rgb_to_yuv420_column_converter #(
  parameter int MAX_HEIGHT  = ryc_pkg::DEF_MAX_HEIGHT,
  parameter int MAX_COLUMNS = ryc_pkg::DEF_MAX_COLUMNS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [ryc_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [ryc_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [ryc_pkg::PIXEL_W-1:0]        s_tdata,   // pixel_word
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // luma, chroma_blue, chroma_red, sub_blue, sub_red
  output logic [ryc_pkg::OUT_W-1:0]          m_tdata,
  output logic [ryc_pkg::OUT_USER_W-1:0]     m_tuser,   // sub_valid, format_error
  output logic                               m_tlast
);

  localparam int DEPTH = MAX_HEIGHT / 2;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int RW    = AW + 1;
  localparam int HB_W  = ($clog2(MAX_HEIGHT + 1) > ryc_pkg::HEIGHT_W) ?
                         $clog2(MAX_HEIGHT + 1) : ryc_pkg::HEIGHT_W;
  localparam int CW    = (MAX_COLUMNS > 2) ? $clog2(MAX_COLUMNS) : 1;
  localparam int CB_W  = ($clog2(MAX_COLUMNS + 1) > ryc_pkg::COLUMNS_W) ?
                         $clog2(MAX_COLUMNS + 1) : ryc_pkg::COLUMNS_W;
  localparam logic [HB_W-1:0] MAX_H = HB_W'(MAX_HEIGHT);
  localparam logic [CB_W-1:0] MAX_C = CB_W'(MAX_COLUMNS);

  // configuration
  logic [ryc_pkg::FORMAT_W-1:0]  pixel_format;
  logic [ryc_pkg::COLUMNS_W-1:0] frame_columns;
  logic [ryc_pkg::HEIGHT_W-1:0]  column_height;

  // pipeline
  logic                          in_valid;
  logic [ryc_pkg::PIXEL_W-1:0]   in_word;
  logic                          out_valid;
  logic                          advance;
  logic                          fire;

  // position and held chroma
  logic [RW-1:0]                 row_count;
  logic [RW-1:0]                 row_count_next;
  logic [CW-1:0]                 column_count;
  logic [CW-1:0]                 column_count_next;
  logic [7:0]                    held_blue;
  logic [7:0]                    held_red;

  logic [HB_W-1:0]               h_raw;
  logic [HB_W-1:0]               h_eff;
  logic [CB_W-1:0]               w_raw;
  logic [CB_W-1:0]               w_eff;
  logic                          restart;
  logic [RW-1:0]                 row_e;
  logic [CW-1:0]                 col_e;
  logic [HB_W-1:0]               row_inc;
  logic [CB_W-1:0]               col_inc;
  logic                          last_row;
  logic                          last_col;

  ryc_pkg::pixel_t               pix;
  ryc_pkg::pair_t                pair_now;
  ryc_pkg::pair_t                pair_rd;
  logic                          wr_en;
  logic                          rd_en;
  logic [9:0]                    blk_blue;
  logic [9:0]                    blk_red;

  logic                          sub_valid_next;
  logic [7:0]                    sub_blue_next;
  logic [7:0]                    sub_red_next;
  logic                          frame_end_next;

  assign advance  = !out_valid || m_tready;
  assign s_tready = !in_valid || advance;
  assign fire     = in_valid && advance;
  assign m_tvalid = out_valid;

  ryc_pixel_math u_math (
    .pixel_format (pixel_format),
    .pixel_word   (in_word),
    .pixel        (pix)
  );

  // effective geometry: clamp then force even
  always_comb begin
    h_raw = HB_W'(column_height);
    if (h_raw < HB_W'(2)) begin
      h_raw = HB_W'(2);
    end else if (h_raw > MAX_H) begin
      h_raw = MAX_H;
    end
    h_eff = {h_raw[HB_W-1:1], 1'b0};
    w_raw = CB_W'(frame_columns);
    if (w_raw < CB_W'(2)) begin
      w_raw = CB_W'(2);
    end else if (w_raw > MAX_C) begin
      w_raw = MAX_C;
    end
    w_eff = {w_raw[CB_W-1:1], 1'b0};
  end

  always_comb begin
    restart  = (HB_W'(row_count) >= h_eff) || (CB_W'(column_count) >= w_eff);
    row_e    = restart ? '0 : row_count;
    col_e    = restart ? '0 : column_count;
    row_inc  = HB_W'(row_e) + HB_W'(1);
    col_inc  = CB_W'(col_e) + CB_W'(1);
    last_row = row_inc >= h_eff;
    last_col = col_inc >= w_eff;
    if (last_row) begin
      row_count_next    = '0;
      column_count_next = last_col ? '0 : col_inc[CW-1:0];
    end else begin
      row_count_next    = row_inc[RW-1:0];
      column_count_next = col_e;
    end
    frame_end_next = last_row && last_col;
  end

  always_comb begin
    pair_now.blue = {1'b0, held_blue} + {1'b0, pix.chroma_blue};
    pair_now.red  = {1'b0, held_red} + {1'b0, pix.chroma_red};
    blk_blue = {1'b0, pair_rd.blue} + {1'b0, pair_now.blue} + 10'd2;
    blk_red  = {1'b0, pair_rd.red} + {1'b0, pair_now.red} + 10'd2;
    rd_en = fire && !pix.format_error && !row_e[0];
    wr_en = fire && !pix.format_error && row_e[0] && !col_e[0];
    sub_valid_next = row_e[0] && col_e[0];
    sub_blue_next  = sub_valid_next ? blk_blue[9:2] : 8'd0;
    sub_red_next   = sub_valid_next ? blk_red[9:2] : 8'd0;
  end

  ryc_pair_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (row_e[AW:1]),
    .wr_data (pair_now),
    .rd_en   (rd_en),
    .rd_addr (row_e[AW:1]),
    .rd_data (pair_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_format  <= ryc_pkg::RST_PIXEL_FORMAT;
      frame_columns <= ryc_pkg::RST_FRAME_COLUMNS;
      column_height <= ryc_pkg::RST_COLUMN_HEIGHT;
      in_valid      <= 1'b0;
      out_valid     <= 1'b0;
      row_count     <= '0;
      column_count  <= '0;
      held_blue     <= 8'd0;
      held_red      <= 8'd0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          ryc_pkg::REG_PIXEL_FORMAT:  pixel_format  <= cfg_data[ryc_pkg::FORMAT_W-1:0];
          ryc_pkg::REG_FRAME_COLUMNS: frame_columns <= cfg_data[ryc_pkg::COLUMNS_W-1:0];
          ryc_pkg::REG_COLUMN_HEIGHT: column_height <= cfg_data[ryc_pkg::HEIGHT_W-1:0];
          default: begin
          end
        endcase
      end
      if (s_tready) begin
        in_valid <= s_tvalid;
      end
      if (advance) begin
        out_valid <= in_valid;
      end
      if (fire && !pix.format_error) begin
        row_count    <= row_count_next;
        column_count <= column_count_next;
        if (!row_e[0]) begin
          held_blue <= pix.chroma_blue;
          held_red  <= pix.chroma_red;
        end
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_word <= s_tdata;
    end
    if (fire) begin
      if (pix.format_error) begin
        m_tdata <= '0;
        m_tuser <= 2'b10;
        m_tlast <= 1'b0;
      end else begin
        m_tdata <= {sub_red_next, sub_blue_next, pix.chroma_red, pix.chroma_blue, pix.luma};
        m_tuser <= {1'b0, sub_valid_next};
        m_tlast <= frame_end_next;
      end
    end
  end

  a_error_clean: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[1]) |-> (m_tdata == '0 && !m_tlast && !m_tuser[0]))
    else $error("error beat carries data");

  a_frame_wrap: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tlast) |-> (row_count == '0 && column_count == '0))
    else $error("frame end without position wrap");

  a_block_row: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |-> !row_count[0])
    else $error("block completed on even row");

  a_take_empty: assert property (@(posedge clk) disable iff (rst)
    !in_valid |-> s_tready)
    else $error("input stage empty but not ready");

endmodule

### rtl/core/ryc_pixel_math.sv
// ----------------------------------------------------------------------------
// ryc_pixel_math
// Unpacks one raw pixel by format and forms its Y, U and V values.
// ----------------------------------------------------------------------------
module ryc_pixel_math (
  input  logic [ryc_pkg::FORMAT_W-1:0] pixel_format,
  input  logic [ryc_pkg::PIXEL_W-1:0]  pixel_word,
  output ryc_pkg::pixel_t              pixel
);

  logic [7:0]         r;
  logic [7:0]         g;
  logic [7:0]         b;
  logic               bad;
  logic [16:0]        y_sum;
  logic signed [17:0] u_sum;
  logic signed [17:0] v_sum;
  logic signed [17:0] u_q;
  logic signed [17:0] v_q;

  always_comb begin
    bad = 1'b0;
    r = 8'd0;
    g = 8'd0;
    b = 8'd0;
    case (pixel_format)
      ryc_pkg::FMT_BGR24: begin
        r = pixel_word[23:16];
        g = pixel_word[15:8];
        b = pixel_word[7:0];
      end
      ryc_pkg::FMT_RGB565: begin
        r = {3'd0, pixel_word[15:11]};
        g = {2'd0, pixel_word[10:5]};
        b = {3'd0, pixel_word[4:0]};
      end
      default: begin
        bad = 1'b1;
      end
    endcase
  end

  assign y_sum = ryc_pkg::WY_R * {9'd0, r} + ryc_pkg::WY_G * {9'd0, g}
               + ryc_pkg::WY_B * {9'd0, b} + ryc_pkg::Y_ROUND;

  assign u_sum = ryc_pkg::WU_R * $signed({10'd0, r}) + ryc_pkg::WU_G * $signed({10'd0, g})
               + ryc_pkg::WU_B * $signed({10'd0, b}) + ryc_pkg::C_ROUND;
  assign v_sum = ryc_pkg::WV_R * $signed({10'd0, r}) + ryc_pkg::WV_G * $signed({10'd0, g})
               + ryc_pkg::WV_B * $signed({10'd0, b}) + ryc_pkg::C_ROUND;

  // floor shift
  assign u_q = u_sum >>> 8;
  assign v_q = v_sum >>> 8;

  always_comb begin
    pixel.format_error = bad;
    pixel.luma         = bad ? 8'd0 : y_sum[15:8];
    pixel.chroma_blue  = bad ? 8'd0 : u_q[7:0] + ryc_pkg::C_OFFSET;
    pixel.chroma_red   = bad ? 8'd0 : v_q[7:0] + ryc_pkg::C_OFFSET;
  end

endmodule

### rtl/core/ryc_pair_store.sv
// ----------------------------------------------------------------------------
// ryc_pair_store
// Row-pair chroma sums of the last even column, one entry per row pair,
// with a registered read port.
// ----------------------------------------------------------------------------
module ryc_pair_store #(
  parameter int DEPTH = ryc_pkg::DEF_MAX_HEIGHT / 2,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic            clk,
  input  logic            wr_en,
  input  logic [AW-1:0]   wr_addr,
  input  ryc_pkg::pair_t  wr_data,
  input  logic            rd_en,
  input  logic [AW-1:0]   rd_addr,
  output ryc_pkg::pair_t  rd_data
);

  ryc_pkg::pair_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stream-level test of the RGB to YUV 4:2:0 column converter. A scoreboard
// class predicts the Y/U/V result of each accepted pixel beat. It tracks the
// column-major position, the even-row hold and the row-pair sums, and checks
// every result beat in order. A short directed pass covers the pixel
// extremes of both formats, unsupported formats, geometry clamping and a
// position restart. Random phases follow under changing register settings
// with random input gaps and random backpressure on the result side.
// ----------------------------------------------------------------------------
module tb_top;
  import ryc_pkg::*;

  localparam int PAIR_DEPTH = DEF_MAX_HEIGHT / 2;

  typedef struct packed {
    logic [7:0] luma;
    logic [7:0] cb;
    logic [7:0] cr;
    logic       sub_valid;
    logic [7:0] sub_blue;
    logic [7:0] sub_red;
    logic       frame_end;
    logic       format_error;
  } yuv_result_t;

  class yuv_scoreboard;
    logic [FORMAT_W-1:0]  fmt;
    logic [COLUMNS_W-1:0] cols;
    logic [HEIGHT_W-1:0]  height;
    int unsigned          row;
    int unsigned          col;
    logic [7:0]           held_u;
    logic [7:0]           held_v;
    logic [PAIR_W-1:0]    pair_u [PAIR_DEPTH];
    logic [PAIR_W-1:0]    pair_v [PAIR_DEPTH];
    bit                   pair_seen [PAIR_DEPTH];
    yuv_result_t          expected_q [$];
    int                   errors;
    int                   results;
    int                   blocks;
    int                   frames;
    int                   fmt_errs;

    function new();
      fmt = RST_PIXEL_FORMAT;
      cols = RST_FRAME_COLUMNS;
      height = RST_COLUMN_HEIGHT;
      row = 0;
      col = 0;
      held_u = '0;
      held_v = '0;
      foreach (pair_seen[i]) pair_seen[i] = 0;
      errors = 0;
      results = 0;
      blocks = 0;
      frames = 0;
      fmt_errs = 0;
    endfunction

    function int even_bound(int v, int maxv);
      if (v < 2) v = 2;
      if (v > maxv) v = maxv;
      return v & ~1;
    endfunction

    function logic [7:0] chroma(int sum);
      int q;
      q = (sum + 128) >>> 8;
      return 8'(q + 128);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function int frame_size();
      return even_bound(height, DEF_MAX_HEIGHT) * even_bound(cols, DEF_MAX_COLUMNS);
    endfunction

    function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_PIXEL_FORMAT:  fmt = val[FORMAT_W-1:0];
        REG_FRAME_COLUMNS: cols = val[COLUMNS_W-1:0];
        REG_COLUMN_HEIGHT: height = val[HEIGHT_W-1:0];
        default: ;
      endcase
    endfunction

    // false if the new geometry would let an odd column read a pair sum never stored
    function bit geometry_safe(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      int h;
      int wd;
      h = even_bound((idx == REG_COLUMN_HEIGHT) ? int'(val[HEIGHT_W-1:0]) : int'(height),
                     DEF_MAX_HEIGHT);
      wd = even_bound((idx == REG_FRAME_COLUMNS) ? int'(val) : int'(cols), DEF_MAX_COLUMNS);
      if (row >= h || col >= wd || col % 2 == 0) return 1;
      for (int r = row; r < h; r++)
        if (r % 2 == 1 && !pair_seen[r >> 1]) return 0;
      return 1;
    endfunction

    function void note_pixel(logic [PIXEL_W-1:0] w);
      int r;
      int g;
      int b;
      int h;
      int wd;
      int idx;
      logic [PAIR_W-1:0] pb;
      logic [PAIR_W-1:0] pr;
      yuv_result_t e;
      e = '0;
      if (fmt == FMT_BGR24) begin
        r = w[23:16];
        g = w[15:8];
        b = w[7:0];
      end else if (fmt == FMT_RGB565) begin
        r = w[15:11];
        g = w[10:5];
        b = w[4:0];
      end else begin
        e.format_error = 1'b1;
        expected_q.push_back(e);
        return;
      end
      h = even_bound(height, DEF_MAX_HEIGHT);
      wd = even_bound(cols, DEF_MAX_COLUMNS);
      if (row >= h || col >= wd) begin
        row = 0;
        col = 0;
      end
      e.luma = 8'((77 * r + 150 * g + 29 * b + 128) >> 8);
      e.cb = chroma(-43 * r - 84 * g + 127 * b);
      e.cr = chroma(127 * r - 106 * g - 21 * b);
      if (row % 2 == 0) begin
        held_u = e.cb;
        held_v = e.cr;
      end else begin
        idx = (row >> 1) % PAIR_DEPTH;
        pb = {1'b0, held_u} + {1'b0, e.cb};
        pr = {1'b0, held_v} + {1'b0, e.cr};
        if (col % 2 == 0) begin
          pair_u[idx] = pb;
          pair_v[idx] = pr;
          pair_seen[idx] = 1;
        end else begin
          e.sub_valid = 1'b1;
          e.sub_blue = 8'((int'(pair_u[idx]) + int'(pb) + 2) >> 2);
          e.sub_red = 8'((int'(pair_v[idx]) + int'(pr) + 2) >> 2);
        end
      end
      row++;
      if (row >= h) begin
        row = 0;
        col++;
        if (col >= wd) begin
          col = 0;
          e.frame_end = 1'b1;
        end
      end
      expected_q.push_back(e);
    endfunction

    function void compare(string name, logic [7:0] exp_v, logic [7:0] act_v);
      if (exp_v !== act_v) begin
        errors++;
        if (errors <= 40)
          $display("%0t: %s mismatch: expected %h actual %h", $time, name, exp_v, act_v);
      end
    endfunction

    function void check_result(logic [OUT_W-1:0] data, logic [OUT_USER_W-1:0] user,
                               logic last);
      yuv_result_t e;
      results++;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 40)
          $display("%0t: result beat with no pixel pending: expected none actual %h/%h/%b",
                   $time, data, user, last);
        return;
      end
      e = expected_q.pop_front();
      compare("luma", e.luma, data[7:0]);
      compare("chroma_blue", e.cb, data[15:8]);
      compare("chroma_red", e.cr, data[23:16]);
      compare("sub_blue", e.sub_blue, data[31:24]);
      compare("sub_red", e.sub_red, data[39:32]);
      compare("sub_valid", {7'd0, e.sub_valid}, {7'd0, user[0]});
      compare("format_error", {7'd0, e.format_error}, {7'd0, user[1]});
      compare("frame_end", {7'd0, e.frame_end}, {7'd0, last});
      if (e.sub_valid) blocks++;
      if (e.frame_end) frames++;
      if (e.format_error) fmt_errs++;
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [PIXEL_W-1:0]     s_tdata;
  logic                   m_tvalid;
  logic                   m_tready;
  logic [OUT_W-1:0]       m_tdata;
  logic [OUT_USER_W-1:0]  m_tuser;
  logic                   m_tlast;

  yuv_scoreboard sb;
  int            pixels_sent = 0;
  int            reg_writes = 0;
  bit            long_hold_req = 0;
  int            long_holds = 0;

  always #1 clk = ~clk;

  rgb_to_yuv420_column_converter u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

  always @(posedge clk) begin
    if (rst === 1'b0 && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser, m_tlast);
  end

  // result side backpressure
  initial begin : rx_side
    int hold;
    int calm_left;
    bit calm;
    hold = 0;
    calm_left = 0;
    calm = 0;
    m_tready = 1'b0;
    wait (rst === 1'b0);
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        hold--;
        m_tready <= 1'b0;
      end else if (long_hold_req) begin
        long_hold_req = 0;
        long_holds++;
        hold = 299;
        m_tready <= 1'b0;
      end else begin
        if (calm_left == 0) begin
          calm = ($urandom % 3 == 0);
          calm_left = $urandom_range(20, 200);
        end
        calm_left--;
        if (calm || $urandom % 4 != 0) begin
          m_tready <= 1'b1;
        end else begin
          m_tready <= 1'b0;
          hold = ($urandom % 5 == 0) ? $urandom_range(8, 40) : $urandom_range(0, 3);
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
    reg_writes++;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic try_geometry(input logic [CFG_INDEX_W-1:0] idx,
                              input logic [CFG_DATA_W-1:0] val);
    if (sb.geometry_safe(idx, val)) write_reg(idx, val);
  endtask

  task automatic send_pixel(input logic [PIXEL_W-1:0] w, input int gap);
    s_tvalid <= 1'b1;
    s_tdata <= w;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_pixel(w);
    pixels_sent++;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic int pick_gap(int mode);
    int r;
    if (mode == 0) return 0;
    r = $urandom % 100;
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [PIXEL_W-1:0] pick_pixel();
    int r;
    r = $urandom % 16;
    if (r == 0) return 24'hffffff;
    if (r == 1) return 24'h000000;
    return PIXEL_W'($urandom);
  endfunction

  initial begin
    logic [PIXEL_W-1:0]   bgr_edge [5];
    logic [PIXEL_W-1:0]   rgb565_edge [5];
    logic [FORMAT_W-1:0]  fmt_val;
    logic [CFG_DATA_W-1:0] h_val;
    logic [CFG_DATA_W-1:0] w_val;
    int                   sel;
    int                   frame;
    int                   n;
    int                   gap_mode;
    int                   phase;
    bgr_edge = '{24'h000000, 24'hffffff, 24'hff0000, 24'h00ff00, 24'h0000ff};
    rgb565_edge = '{24'h00ffff, 24'h00f800, 24'h0007e0, 24'h00001f, 24'hff0000};
    sb = new();
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // component extremes, reset settings
    foreach (bgr_edge[i]) send_pixel(bgr_edge[i], 0);
    wait_idle();
    write_reg(REG_PIXEL_FORMAT, {6'd0, FMT_RGB565});
    foreach (rgb565_edge[i]) send_pixel(rgb565_edge[i], i % 2);
    // unsupported formats, upper data bits set on one write
    wait_idle();
    write_reg(REG_PIXEL_FORMAT, 10'd0);
    send_pixel(24'hffffff, 0);
    wait_idle();
    write_reg(REG_PIXEL_FORMAT, {6'h3f, 4'hf});
    send_pixel(24'h123456, 0);
    wait_idle();
    write_reg(REG_PIXEL_FORMAT, 10'd3);
    send_pixel(24'hffffff, 0);
    // shrink below the current position: frame restarts
    wait_idle();
    write_reg(REG_PIXEL_FORMAT, {6'd0, FMT_BGR24});
    write_reg(REG_COLUMN_HEIGHT, 10'd2);
    write_reg(REG_FRAME_COLUMNS, 10'd2);
    send_pixel(24'hffffff, 0);
    send_pixel(24'h000000, 0);
    send_pixel(24'h0000ff, 0);
    send_pixel(24'hff00ff, 0);
    // geometry clamped up from zero and one
    wait_idle();
    write_reg(REG_COLUMN_HEIGHT, 10'd0);
    write_reg(REG_FRAME_COLUMNS, 10'd1);
    repeat (4) send_pixel(pick_pixel(), 0);
    // odd height rounds down, oversize columns clamp
    wait_idle();
    write_reg(REG_COLUMN_HEIGHT, 10'd3);
    write_reg(REG_FRAME_COLUMNS, 10'h3ff);
    repeat (4) send_pixel(pick_pixel(), 1);

    phase = 0;
    while (pixels_sent < 1450) begin
      wait_idle();
      sel = $urandom % 10;
      fmt_val = (sel < 4) ? FMT_BGR24 : (sel < 8) ? FMT_RGB565 : FORMAT_W'($urandom);
      if (phase < 2) fmt_val = FMT_BGR24;
      write_reg(REG_PIXEL_FORMAT, {6'($urandom), fmt_val});
      if (phase == 0) begin
        h_val = 10'd256;
        w_val = 10'd2;
      end else if (phase == 1) begin
        h_val = 10'd2;
        w_val = 10'd512;
      end else if ($urandom % 6 == 0) begin
        h_val = 10'($urandom);
        w_val = 10'($urandom);
      end else begin
        h_val = 10'(2 * $urandom_range(1, 6));
        w_val = 10'(2 * $urandom_range(1, 4));
      end
      try_geometry(REG_COLUMN_HEIGHT, h_val);
      try_geometry(REG_FRAME_COLUMNS, w_val);
      frame = sb.frame_size();
      if (frame > 600) n = $urandom_range(16, 96);
      else if ($urandom % 4 == 0) n = $urandom_range(1, frame);
      else n = frame * ((frame > 100) ? 1 : $urandom_range(1, 3));
      gap_mode = $urandom % 4;
      if (phase == 3) begin
        gap_mode = 0;
        long_hold_req = 1;
        // enough beats to fill both stages during the long hold
        if (n < 16) n = 16;
      end
      for (int i = 0; i < n; i++) send_pixel(pick_pixel(), pick_gap(gap_mode));
      phase++;
    end

    wait_idle();
    repeat (8) @(posedge clk);
    $display("run: %0d pixel beats over %0d phases, %0d register writes, %0d long holds",
             pixels_sent, phase, reg_writes, long_holds);
    $display("results: %0d beats, %0d 2x2 blocks, %0d frame ends, %0d format errors",
             sb.results, sb.blocks, sb.frames, sb.fmt_errs);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

### rgb_to_yuv420_column_converter.f
rtl/core/ryc_pkg.sv
rtl/core/ryc_pixel_math.sv
rtl/core/ryc_pair_store.sv
rtl/core/rgb_to_yuv420_column_converter.sv
test/tb_top.sv
